@@ src/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, field codes and defaults for the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // Default number of cache slots.
    localparam int CACHE_ENTRIES_DEF = 16;

    // Field widths; IP, MAC and type widths are fixed by the packet format.
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TYPE_W  = 16;
    localparam int INDEX_W = 4;
    localparam int CODE_W  = 2;
    localparam int DATA_W  = 48;

    // Accepted header values.
    localparam logic [TYPE_W-1:0] HW_ETHERNET = 16'h0001;
    localparam logic [TYPE_W-1:0] PROTO_IPV4  = 16'h0800;
    localparam logic [TYPE_W-1:0] OP_REQUEST  = 16'h0001;
    localparam logic [TYPE_W-1:0] OP_REPLY    = 16'h0002;

    // Result status codes.
    localparam logic [CODE_W-1:0] ST_DROP  = 2'd0;
    localparam logic [CODE_W-1:0] ST_LEARN = 2'd1;
    localparam logic [CODE_W-1:0] ST_REPLY = 2'd2;

    // Cache action codes.
    localparam logic [CODE_W-1:0] ACT_UPDATE = 2'd0;
    localparam logic [CODE_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [CODE_W-1:0] ACT_FULL   = 2'd2;
    localparam logic [CODE_W-1:0] ACT_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_LOCAL_IP  = 1'b0;
    localparam logic REG_LOCAL_MAC = 1'b1;

    // Search token that walks along the row of cache cells.
    typedef struct packed {
        logic               good;   // header types accepted
        logic               reply;  // request aimed at the local IP
        logic               done;   // slot already found or filled
        logic               hit;    // an existing entry was updated
        logic [INDEX_W-1:0] idx;    // slot that was touched
        logic [IP_W-1:0]    ip;     // sender IP
        logic [MAC_W-1:0]   mac;    // sender MAC
    } tok_t;

endpackage

@@ src/arpc_cell.sv @@
// ----------------------------------------------------------------------------
// ARP cache cell
// One cache slot. Checks the passing token against its entry, updates or
// fills the entry, and hands the registered token on to the next cell.
// ----------------------------------------------------------------------------
module arpc_cell #(
    parameter int SLOT_ID = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  arpc_pkg::tok_t in_tok,
    output logic          out_vld,
    output arpc_pkg::tok_t out_tok
);
    import arpc_pkg::*;

    logic             valid_reg;
    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             tok_vld_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             act;
    logic             match;
    logic             fill;

    // Only a live, well-typed token that has not settled yet touches the slot.
    // Valid slots are contiguous, so the first empty slot is the free one.
    assign act   = in_vld && in_tok.good && !in_tok.done;
    assign match = act && valid_reg && (ip_reg == in_tok.ip);
    assign fill  = act && !valid_reg;

    // Token seen by the next cell.
    always_comb
    begin
        tok_next      = in_tok;
        tok_next.done = in_tok.done || match || fill;
        tok_next.hit  = in_tok.hit || match;
        if (match || fill)
        begin
            tok_next.idx = INDEX_W'(SLOT_ID);
        end
    end

    // Slot valid flag and token valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= in_vld;
            if (fill)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // Entry contents and token payload.
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (fill)
        begin
            ip_reg <= in_tok.ip;
        end
        if (match || fill)
        begin
            mac_reg <= in_tok.mac;
        end
    end

    assign out_vld = tok_vld_reg;
    assign out_tok = tok_reg;

endmodule

@@ src/arp_cache_and_responder_unit.sv @@
// ----------------------------------------------------------------------------
// ARP cache and responder
// Learns sender IP/MAC pairs from received ARP packets in a row of cache cells
// and produces reply fields for requests aimed at the local IP.
// ----------------------------------------------------------------------------
// The result strobe (done) rises once the token has left the last cell and been
// registered; a dropped packet takes the same path and time.
// One packet at a time: the token walks through the row of cells, one cell per
// cycle, and busy stays high until it leaves; no new packet is taken meanwhile.
// Reset clears every cache slot and both local address registers at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module arp_cache_and_responder_unit #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration writes
    input  logic                              wr_en,
    input  logic                              wr_index,
    input  logic [arpc_pkg::DATA_W-1:0]       wr_data,
    // Packet command
    input  logic                              start,
    output logic                              busy,
    input  logic [arpc_pkg::TYPE_W-1:0]       hw_type,
    input  logic [arpc_pkg::TYPE_W-1:0]       proto_type,
    input  logic [arpc_pkg::TYPE_W-1:0]       opcode,
    input  logic [arpc_pkg::MAC_W-1:0]        sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]         sender_ip,
    input  logic [arpc_pkg::IP_W-1:0]         target_ip,
    // Result
    output logic                              done,
    output logic [arpc_pkg::CODE_W-1:0]       status,
    output logic [arpc_pkg::CODE_W-1:0]       cache_action,
    output logic [arpc_pkg::INDEX_W-1:0]      entry_index,
    output logic [arpc_pkg::MAC_W-1:0]        reply_dest_mac,
    output logic [arpc_pkg::IP_W-1:0]         reply_dest_ip,
    output logic [arpc_pkg::MAC_W-1:0]        reply_src_mac,
    output logic [arpc_pkg::IP_W-1:0]         reply_src_ip
);
    import arpc_pkg::*;

    logic [IP_W-1:0]    local_ip_reg;
    logic [MAC_W-1:0]   local_mac_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CODE_W-1:0]  status_reg;
    logic [CODE_W-1:0]  action_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [MAC_W-1:0]   tgt_mac_reg;
    logic [IP_W-1:0]    dest_ip_reg;
    logic [MAC_W-1:0]   src_mac_reg;
    logic [IP_W-1:0]    src_ip_reg;

    logic [CACHE_ENTRIES:0] vld_chain;
    tok_t                   tok_chain [CACHE_ENTRIES+1];
    tok_t                   tok_head;
    logic                   accept;
    tok_t                   last_tok;

    assign accept = start && !busy_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= '0;
            local_mac_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_LOCAL_IP:  local_ip_reg  <= wr_data[IP_W-1:0];
                REG_LOCAL_MAC: local_mac_reg <= wr_data[MAC_W-1:0];
                default:       ;
            endcase
        end
    end

    // Build the search token from the accepted beat.
    always_comb
    begin
        tok_head       = '0;
        tok_head.good  = (hw_type == HW_ETHERNET) && (proto_type == PROTO_IPV4);
        tok_head.reply = (opcode == OP_REQUEST) && (target_ip == local_ip_reg);
        tok_head.ip    = sender_ip;
        tok_head.mac   = sender_mac;
    end
    assign tok_chain[0] = tok_head;
    assign vld_chain[0] = accept;

    // Row of cache cells; the token moves one cell per cycle.
    for (genvar g = 0; g < CACHE_ENTRIES; g++)
    begin : g_cell
        arpc_cell #(
            .SLOT_ID (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (vld_chain[g]),
            .in_tok  (tok_chain[g]),
            .out_vld (vld_chain[g+1]),
            .out_tok (tok_chain[g+1])
        );
    end

    assign last_tok = tok_chain[CACHE_ENTRIES];

    // Busy from the accepting edge until the token leaves the row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_chain[CACHE_ENTRIES];
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (vld_chain[CACHE_ENTRIES])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Result beat from the token that left the last cell.
    always_ff @(posedge clk)
    begin
        if (vld_chain[CACHE_ENTRIES])
        begin
            status_reg   <= ST_DROP;
            action_reg   <= ACT_NONE;
            index_reg    <= '0;
            tgt_mac_reg  <= '0;
            dest_ip_reg  <= '0;
            src_mac_reg  <= '0;
            src_ip_reg   <= '0;
            if (last_tok.good)
            begin
                if (last_tok.hit)
                begin
                    action_reg <= ACT_UPDATE;
                    index_reg  <= last_tok.idx;
                end
                else if (last_tok.done)
                begin
                    action_reg <= ACT_ADD;
                    index_reg  <= last_tok.idx;
                end
                else
                begin
                    action_reg <= ACT_FULL;
                end
                status_reg <= ST_LEARN;
                if (last_tok.reply)
                begin
                    status_reg   <= ST_REPLY;
                    tgt_mac_reg  <= last_tok.mac;
                    dest_ip_reg  <= last_tok.ip;
                    src_mac_reg  <= local_mac_reg;
                    src_ip_reg   <= local_ip_reg;
                end
            end
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign cache_action   = action_reg;
    assign entry_index    = index_reg;
    assign reply_dest_mac = tgt_mac_reg;
    assign reply_dest_ip  = dest_ip_reg;
    assign reply_src_mac  = src_mac_reg;
    assign reply_src_ip   = src_ip_reg;

    // At most one token is in the row at any time.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(vld_chain))
        else $error("more than one search token in the cell row");

    // An accepted beat keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted beat");

    // The result beat comes out only once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a packet is still in flight");

    // A dropped packet never touches the cache.
    a_drop_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DROP) |-> (cache_action == ACT_NONE))
        else $error("dropped packet reported a cache action");

endmodule
